@@ sv/per_key_fixed_window_rate_limiter_top_defines.svh @@
`ifndef PER_KEY_FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH
`define PER_KEY_FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH

// Check that a property holds on every rising clock edge outside reset
`define RLIM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition is followed by a consequence on the next edge
`define RLIM_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rlim_pkg.sv @@
`timescale 1ns / 1ps
package rlim_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int PROBE_W     = SLOT_W + 1;
    localparam int HASH_W      = 16;
    localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);
    localparam logic [8:0] CLEARED_MAX = 9'd511;

    // Command codes
    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_CLEAN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register indexes
    localparam logic CFG_RATE_LIMIT = 1'b0;
    localparam logic CFG_IDLE_SECS  = 1'b1;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [15:0] count;
        logic [31:0] win_sec;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    // Fold eight bytes of a word into the low bits of a DJB2 hash, top byte first
    function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] h_in,
                                                   input logic [63:0] w);
        logic [HASH_W-1:0] h;
        h = h_in;
        for (int b = 7; b >= 0; b--) begin
            h = (h << 5) + h + HASH_W'(w[b*8 +: 8]);
        end
        return h;
    endfunction

endpackage

@@ sv/per_key_fixed_window_rate_limiter_top.sv @@
`timescale 1ns / 1ps
// Per-client fixed-window request limiter.
// Input stream: one item per command. tuser carries the command (check, clean,
// clear); tdata carries the 128-bit client key and the current second.
// Output stream: one item per input item with allowed, table_full and the
// number of entries freed by a clean command.
// A check hashes the key, then reads its home slot, then probes the slot
// table with a valid test and then a compare and write back for each slot
// visited; a hit in the home slot ends after the first probe, and each
// further probe repeats both steps. The single-port slot memory sets this.
// A clean walks all slots, each with a read state and then a check state; a
// clear empties all valid bits in a single state.
// One item is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even if not yet taken.
// If the receiver stalls with a result held, a finished item waits inside.
// Synchronous active-low reset empties the table and loads the default
// registers (limit 100 per second, idle age 10 seconds). The user must write
// configuration via the plain write port while idle; nothing enforces it.
`include "per_key_fixed_window_rate_limiter_top_defines.svh"
module per_key_fixed_window_rate_limiter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // key_high [63:0], key_low [127:64], now_seconds [159:128]
    input  logic [159:0] i_s_axis_tdata,
    // command [1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // allowed [0], table_full [1], cleared_count [10:2], zero [15:11]
    output logic [15:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_HASH     = 9'b000000010,
        ST_PROBE    = 9'b000000100,
        ST_CMP      = 9'b000001000,
        ST_CLEAN_RD = 9'b000010000,
        ST_CLEAN_CK = 9'b000100000,
        ST_CLEAR    = 9'b001000000,
        ST_DONE     = 9'b010000000,
        ST_WAIT     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_rate_limit;
    logic [15:0] r_idle_secs;

    logic [rlim_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [rlim_pkg::SLOT_W-1:0]      r_slot;
    logic [rlim_pkg::PROBE_W-1:0]     r_probe;
    logic [63:0]                      r_key_high;
    logic [63:0]                      r_key_low;
    logic [31:0]                      r_now;
    logic                             r_allowed;
    logic                             r_full;
    logic [8:0]                       r_cleared;
    logic                             r_out_valid;
    logic [15:0]                      r_out_data;

    logic                        s_accept;
    logic                        h_done;
    logic [rlim_pkg::SLOT_W-1:0] h_slot;
    logic                        ram_we;
    rlim_pkg::t_slot             ram_wdata;
    rlim_pkg::t_slot             ram_rdata;
    logic                        key_match;
    logic                        idle_old;
    logic [31:0]                 age;
    logic                        out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Key hash unit
    rlim_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept && (i_s_axis_tuser == rlim_pkg::CMD_CHECK)),
        .i_key_high (i_s_axis_tdata[63:0]),
        .i_key_low  (i_s_axis_tdata[127:64]),
        .o_done     (h_done),
        .o_slot     (h_slot)
    );

    // Slot memory: key, count and window start
    rlim_ram #(
        .WIDTH (rlim_pkg::SLOT_BITS),
        .DEPTH (rlim_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_slot),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign key_match = (ram_rdata.key_high == r_key_high) && (ram_rdata.key_low == r_key_low);
    assign age       = r_now - ram_rdata.win_sec;
    assign idle_old  = (r_now >= ram_rdata.win_sec) && (age > {16'd0, r_idle_secs});

    // Write back a new entry, a restarted window or a bumped count
    always_comb begin
        ram_we              = 1'b0;
        ram_wdata.key_high  = r_key_high;
        ram_wdata.key_low   = r_key_low;
        ram_wdata.count     = 16'd1;
        ram_wdata.win_sec   = r_now;
        if (r_state == ST_PROBE) begin
            ram_we = (r_probe != rlim_pkg::PROBE_W'(rlim_pkg::TABLE_DEPTH)) && !r_valid[r_slot];
        end else if (r_state == ST_CMP && key_match) begin
            if (r_now > ram_rdata.win_sec) begin
                ram_we = 1'b1;
            end else if (ram_rdata.count < r_rate_limit) begin
                ram_we            = 1'b1;
                ram_wdata.count   = ram_rdata.count + 16'd1;
                ram_wdata.win_sec = ram_rdata.win_sec;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        rlim_pkg::CMD_CHECK: n_state = ST_HASH;
                        rlim_pkg::CMD_CLEAN: n_state = ST_CLEAN_RD;
                        rlim_pkg::CMD_CLEAR: n_state = ST_CLEAR;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_HASH:     n_state = h_done ? ST_WAIT : ST_HASH;
            ST_WAIT:     n_state = ST_PROBE;
            ST_PROBE: begin
                if (r_probe == rlim_pkg::PROBE_W'(rlim_pkg::TABLE_DEPTH) || !r_valid[r_slot]) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:      n_state = key_match ? ST_DONE : ST_PROBE;
            ST_CLEAN_RD: n_state = ST_CLEAN_CK;
            ST_CLEAN_CK: begin
                n_state = (r_slot == rlim_pkg::SLOT_W'(rlim_pkg::TABLE_DEPTH - 1)) ?
                          ST_DONE : ST_CLEAN_RD;
            end
            ST_CLEAR:    n_state = ST_DONE;
            ST_DONE:     n_state = out_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rate_limit <= 16'd100;
            r_idle_secs  <= 16'd10;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rlim_pkg::CFG_RATE_LIMIT: r_rate_limit <= i_cfg_data;
                    rlim_pkg::CFG_IDLE_SECS:  r_idle_secs  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (r_state == ST_CLEAN_CK && r_valid[r_slot] && idle_old) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (r_state == ST_CLEAR) begin
                r_valid <= '0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        // Latch the accepted item
        if (s_accept) begin
            r_key_high <= i_s_axis_tdata[63:0];
            r_key_low  <= i_s_axis_tdata[127:64];
            r_now      <= i_s_axis_tdata[159:128];
            r_allowed  <= 1'b0;
            r_full     <= 1'b0;
            r_cleared  <= '0;
            r_slot     <= '0;
            r_probe    <= '0;
        end

        case (r_state)
            ST_HASH: begin
                r_slot <= h_slot;
            end
            ST_PROBE: begin
                if (r_probe == rlim_pkg::PROBE_W'(rlim_pkg::TABLE_DEPTH)) begin
                    r_allowed <= 1'b1;
                    r_full    <= 1'b1;
                end else if (!r_valid[r_slot]) begin
                    r_allowed <= 1'b1;
                end
            end
            ST_CMP: begin
                if (key_match) begin
                    r_allowed <= ram_we;
                end else begin
                    r_slot  <= r_slot + rlim_pkg::SLOT_W'(1);
                    r_probe <= r_probe + rlim_pkg::PROBE_W'(1);
                end
            end
            ST_CLEAN_CK: begin
                if (r_valid[r_slot] && idle_old && r_cleared != rlim_pkg::CLEARED_MAX) begin
                    r_cleared <= r_cleared + 9'd1;
                end
                r_slot <= r_slot + rlim_pkg::SLOT_W'(1);
            end
            default: ;
        endcase

        // Load the output register
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= {5'd0, r_cleared, r_full, r_allowed};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `RLIM_ASSERT(a_hash_only_in_hash, h_done |-> (r_state == ST_HASH), "hash done outside hash wait")
    `RLIM_ASSERT(a_probe_bound, (r_state == ST_PROBE) |-> (r_probe <= rlim_pkg::PROBE_W'(rlim_pkg::TABLE_DEPTH)), "probe overrun")
    `RLIM_ASSERT_NEXT(a_clear_empties, r_state == ST_CLEAR, r_valid == '0, "clear left entries")
    `RLIM_ASSERT_NEXT(a_full_allowed, r_state == ST_DONE && r_full, r_allowed || !r_full, "full request not allowed")

endmodule

@@ sv/rlim_ram.sv @@
`timescale 1ns / 1ps
module rlim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rlim_hash.sv @@
`timescale 1ns / 1ps
module rlim_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key_high,
    input  logic [63:0]                i_key_low,
    output logic                       o_done,
    output logic [rlim_pkg::SLOT_W-1:0] o_slot
);

    logic                        r_busy;
    logic                        r_done;
    logic [rlim_pkg::HASH_W-1:0] r_h;
    logic [63:0]                 r_low;

    // Mix the upper word, then the lower word on the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_h   <= rlim_pkg::mix_word(rlim_pkg::HASH_SEED, i_key_high);
            r_low <= i_key_low;
        end else if (r_busy) begin
            r_h <= rlim_pkg::mix_word(r_h, r_low);
        end
    end

    // Table depth is a power of two: modulo is the low bits
    assign o_done = r_done;
    assign o_slot = r_h[rlim_pkg::SLOT_W-1:0];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] now;
    } t_request;

    typedef struct {
        logic       allowed;
        logic       table_full;
        logic [8:0] cleared;
    } t_verdict;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata = '0;
    logic [1:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [15:0]  o_m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [15:0]  i_cfg_data = '0;

    per_key_fixed_window_rate_limiter_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow table and registers
    logic [15:0]     limit_reg = 16'd100;
    logic [15:0]     idle_reg  = 16'd10;
    logic            sh_valid [rlim_pkg::TABLE_DEPTH];
    rlim_pkg::t_slot sh_slot  [rlim_pkg::TABLE_DEPTH];

    t_request pending_items[$];
    t_verdict expected_verdicts[$];
    bit       item_taken = 1'b0;
    bit       failed = 1'b0;
    int       items_in = 0;
    int       quiet_cycles = 0;

    // DJB2 over the 16 key bytes, most significant byte first
    function automatic int unsigned home_of(logic [63:0] hi, logic [63:0] lo);
        logic [127:0] k;
        logic [63:0]  h;
        k = {hi, lo};
        h = 64'd5381;
        for (int b = 15; b >= 0; b--) h = h * 64'd33 + 64'(k[b*8 +: 8]);
        return int'(h % rlim_pkg::TABLE_DEPTH);
    endfunction

    function automatic t_verdict predict_verdict(t_request r);
        t_verdict    v;
        int unsigned s;
        bit          done;
        v = '{1'b0, 1'b0, 9'd0};
        done = 1'b0;
        case (r.cmd)
            rlim_pkg::CMD_CHECK: begin
                s = home_of(r.key_high, r.key_low);
                for (int i = 0; i < rlim_pkg::TABLE_DEPTH && !done; i++) begin
                    if (!sh_valid[s]) begin
                        sh_valid[s] = 1'b1;
                        sh_slot[s] = '{r.key_high, r.key_low, 16'd1, r.now};
                        v.allowed = 1'b1;
                        done = 1'b1;
                    end else if (sh_slot[s].key_high == r.key_high &&
                                 sh_slot[s].key_low == r.key_low) begin
                        if (r.now > sh_slot[s].win_sec) begin
                            sh_slot[s].count = 16'd1;
                            sh_slot[s].win_sec = r.now;
                            v.allowed = 1'b1;
                        end else if (sh_slot[s].count < limit_reg) begin
                            sh_slot[s].count++;
                            v.allowed = 1'b1;
                        end
                        done = 1'b1;
                    end
                    s = (s + 1) % rlim_pkg::TABLE_DEPTH;
                end
                if (!done) begin
                    v.allowed = 1'b1;
                    v.table_full = 1'b1;
                end
            end
            rlim_pkg::CMD_CLEAN: begin
                for (int i = 0; i < rlim_pkg::TABLE_DEPTH; i++) begin
                    if (sh_valid[i] && r.now >= sh_slot[i].win_sec &&
                        (r.now - sh_slot[i].win_sec) > 32'(idle_reg)) begin
                        sh_valid[i] = 1'b0;
                        if (v.cleared != rlim_pkg::CLEARED_MAX) v.cleared++;
                    end
                end
            end
            rlim_pkg::CMD_CLEAR: begin
                for (int i = 0; i < rlim_pkg::TABLE_DEPTH; i++) sh_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Idle gaps about 27 in 100, none across a middle stretch
    function automatic bit take_gap();
        if (items_in >= 150 && items_in < 270) return 1'b0;
        return $urandom_range(99) < 27;
    endfunction

    // Driver: present the next item at the falling edge
    always @(negedge i_clk) begin
        t_request r;
        if (i_rst_n && (!i_s_axis_tvalid || item_taken)) begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && !take_gap()) begin
                r = pending_items.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= r.cmd;
                i_s_axis_tdata  <= {r.now, r.key_low, r.key_high};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= i_rst_n && !take_gap();
    end

    // Monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_request r;
        t_verdict e;
        t_verdict got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r.cmd      = i_s_axis_tuser;
                r.key_high = i_s_axis_tdata[63:0];
                r.key_low  = i_s_axis_tdata[127:64];
                r.now      = i_s_axis_tdata[159:128];
                expected_verdicts.push_back(predict_verdict(r));
                item_taken = 1'b1;
                items_in++;
                quiet_cycles = 0;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                quiet_cycles = 0;
                got = '{o_m_axis_tdata[0], o_m_axis_tdata[1], o_m_axis_tdata[10:2]};
                if (expected_verdicts.size() == 0) begin
                    $error("result with no item outstanding: %h", o_m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    e = expected_verdicts.pop_front();
                    if (got.allowed !== e.allowed) begin
                        $error("allowed: expected %0d actual %0d", e.allowed, got.allowed);
                        failed = 1'b1;
                    end
                    if (got.table_full !== e.table_full) begin
                        $error("table_full: expected %0d actual %0d",
                               e.table_full, got.table_full);
                        failed = 1'b1;
                    end
                    if (got.cleared !== e.cleared) begin
                        $error("cleared_count: expected %0d actual %0d",
                               e.cleared, got.cleared);
                        failed = 1'b1;
                    end
                end
            end
            if (quiet_cycles > 20000) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    task automatic push_item(logic [1:0] c, logic [63:0] hi, logic [63:0] lo,
                             logic [31:0] t);
        t_request r;
        r = '{c, hi, lo, t};
        pending_items.push_back(r);
    endtask

    // Hold until every item has been taken and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_s_axis_tvalid || expected_verdicts.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == rlim_pkg::CFG_RATE_LIMIT) limit_reg = val;
        else idle_reg = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n, logic [15:0] lim, logic [15:0] idle);
        logic [63:0] pool_hi [16];
        logic [63:0] pool_lo [16];
        logic [31:0] t;
        int          k;
        int          pick;
        write_reg(rlim_pkg::CFG_RATE_LIMIT, lim);
        write_reg(rlim_pkg::CFG_IDLE_SECS, idle);
        for (int i = 0; i < 16; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) ;
            else if (pick < 85) t = t + 1;
            else if (pick < 92) t = t + $urandom_range(40);
            else t = t - $urandom_range(3);
            pick = $urandom_range(99);
            k = $urandom_range(15);
            if (pick < 78) push_item(rlim_pkg::CMD_CHECK, pool_hi[k], pool_lo[k], t);
            else if (pick < 84) push_item(rlim_pkg::CMD_CHECK, {$urandom, $urandom},
                                          {$urandom, $urandom}, t);
            else if (pick < 93) push_item(rlim_pkg::CMD_CLEAN, {$urandom, $urandom},
                                          {$urandom, $urandom}, t);
            else if (pick < 96) push_item(rlim_pkg::CMD_CLEAR, {$urandom, $urandom},
                                          {$urandom, $urandom}, t);
            else push_item(rlim_pkg::CMD_UNUSED, {$urandom, $urandom},
                           {$urandom, $urandom}, t);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < rlim_pkg::TABLE_DEPTH; i++) sh_valid[i] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, backwards time, window restart
        push_item(rlim_pkg::CMD_CHECK, '0, '0, 32'd0);
        push_item(rlim_pkg::CMD_CHECK, '1, '1, 32'hFFFF_FFFF);
        push_item(rlim_pkg::CMD_CHECK, '1, '1, 32'hFFFF_FFFF);
        push_item(rlim_pkg::CMD_CHECK, '1, '1, 32'd0);
        push_item(rlim_pkg::CMD_CHECK, '0, '0, 32'd1);
        push_item(rlim_pkg::CMD_CHECK, '0, '1, 32'd1);
        push_item(rlim_pkg::CMD_CHECK, '1, '0, 32'd1);
        push_item(rlim_pkg::CMD_UNUSED, '1, '1, 32'hFFFF_FFFF);
        push_item(rlim_pkg::CMD_CLEAN, '0, '0, 32'd5);
        push_item(rlim_pkg::CMD_CLEAN, '1, '1, 32'hFFFF_FFFF);
        push_item(rlim_pkg::CMD_CHECK, '1, '1, 32'hFFFF_FFFF);
        push_item(rlim_pkg::CMD_CLEAR, '1, '1, 32'd0);
        push_item(rlim_pkg::CMD_CHECK, '1, '1, 32'd0);
        wait_drained();

        // Zero limit: first request per second passes, repeats are denied
        write_reg(rlim_pkg::CFG_RATE_LIMIT, 16'd0);
        write_reg(rlim_pkg::CFG_IDLE_SECS, 16'd0);
        push_item(rlim_pkg::CMD_CHECK, 64'h1234, 64'h5678, 32'd7);
        push_item(rlim_pkg::CMD_CHECK, 64'h1234, 64'h5678, 32'd7);
        push_item(rlim_pkg::CMD_CHECK, 64'h1234, 64'h5678, 32'd8);
        push_item(rlim_pkg::CMD_CLEAN, '0, '0, 32'd8);
        push_item(rlim_pkg::CMD_CLEAN, '0, '0, 32'd9);
        push_item(rlim_pkg::CMD_CLEAR, '0, '0, 32'd9);
        wait_drained();

        // Fill the table, then overflow it
        write_reg(rlim_pkg::CFG_RATE_LIMIT, 16'hFFFF);
        write_reg(rlim_pkg::CFG_IDLE_SECS, 16'hFFFF);
        for (int i = 0; i < rlim_pkg::TABLE_DEPTH + 4; i++)
            push_item(rlim_pkg::CMD_CHECK, {$urandom, $urandom}, {$urandom, $urandom},
                      32'd100);
        push_item(rlim_pkg::CMD_CLEAN, '0, '0, 32'd200);
        push_item(rlim_pkg::CMD_CLEAR, '0, '0, 32'd200);
        wait_drained();

        random_phase(70, 16'd3, 16'd2);
        random_phase(70, 16'd0, 16'd0);
        random_phase(70, 16'hFFFF, 16'hFFFF);
        random_phase(70, 16'd1, 16'd5);

        repeat (50) @(negedge i_clk);
        if (!failed && expected_verdicts.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
